@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/sdepq_pkg.sv @@
// package: widths, request codes, state type and cell control word
package sdepq_pkg;

   localparam int DATA_W       = 32;
   localparam int REQ_W        = 2;
   localparam int COUNT_OUT_W  = 5;
   localparam int DEF_CAPACITY = 16;

   localparam logic signed [DATA_W-1:0] EMPTY_VALUE = -32'sd1;

   typedef enum logic [REQ_W-1:0] {
      OP_INSERT     = 2'd0,
      OP_REMOVE_MIN = 2'd1,
      OP_REMOVE_MAX = 2'd2
   } req_op_type;

   typedef enum logic {
      ST_ACCEPT,
      ST_REPORT
   } fsm_state_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                     ins;
      logic                     rmax;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

@@ rtl/sdepq_if.sv @@
// request and response channel interfaces
interface sdepq_req_if;
   import sdepq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, req_type, value, input ready);
   modport sink   (input valid, req_type, value, output ready);
endinterface

interface sdepq_rsp_if;
   import sdepq_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] min_value;
   logic signed [DATA_W-1:0] max_value;
   logic [COUNT_OUT_W-1:0]   count;
   logic                     is_empty;
   logic                     insert_dropped;

   modport source (output valid, min_value, max_value, count, is_empty, insert_dropped,
                   input ready);
   modport sink   (input valid, min_value, max_value, count, is_empty, insert_dropped,
                   output ready);
endinterface

@@ rtl/sdepq_cell.sv @@
// one cell of the sorted row: holds a value, shifts right on insert, left on remove-max
module sdepq_cell (
   input  logic                               clock,
   input  sdepq_pkg::cell_ctrl_type           ctrl,
   input  logic                               occupied,
   input  logic                               left_take,
   input  logic signed [sdepq_pkg::DATA_W-1:0] left_value,
   input  logic signed [sdepq_pkg::DATA_W-1:0] right_value,
   output logic signed [sdepq_pkg::DATA_W-1:0] value,
   output logic                               take
);
   import sdepq_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;

   // this cell and all to its right move for the new word
   assign take = !occupied || (value_ff < ctrl.value);

   // next value: keep, load new word, take left neighbor, or take right neighbor
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins && take) begin
         value_in = left_take ? left_value : ctrl.value;
      end else if (ctrl.rmax) begin
         value_in = right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule

@@ rtl/sorted_double_ended_priority_queue_top.sv @@
// top level: row of sorted cells, fill count, report stage and response register
//
//  channel | dir | payload                                        | handshake
//  req_bus | in  | req_type, value                                | valid/ready
//  rsp_bus | out | min_value, max_value, count, is_empty,          | valid/ready
//          |     | insert_dropped                                 |
//
// Each word has an accept cycle, then a report cycle: the accept cycle updates every cell of
// the row at once, the report cycle loads min and max of the row into the response register.
// req ready is low in the report cycle and while an untaken response would be overwritten.
// Synchronous reset empties the queue and the response register; cell contents are not reset.
// A stall on rsp_bus holds the response and blocks further requests.
module sorted_double_ended_priority_queue_top #(
   parameter int CAPACITY = sdepq_pkg::DEF_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   sdepq_req_if.sink   req_bus,
   sdepq_rsp_if.source rsp_bus
);
   import sdepq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   fsm_state_type            state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     drop_ff, drop_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_min_ff, rsp_max_ff;
   logic [COUNT_OUT_W-1:0]   rsp_count_ff;
   logic                     rsp_empty_ff, rsp_drop_ff;

   logic                     accept;
   logic                     req_ready;
   logic                     load_rsp;
   logic                     full, empty;
   req_op_type               op;
   cell_ctrl_type            ctrl;

   logic signed [DATA_W-1:0] cell_val [CAPACITY];
   logic                     cell_take [CAPACITY];

   logic [CNT_W-1:0]         last_pos;
   logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

   assign accept = req_bus.valid && req_ready;
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);
   assign op     = req_op_type'(req_bus.req_type);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCEPT: if (accept) state_in = ST_REPORT;
         ST_REPORT: state_in = ST_ACCEPT;
         default:   state_in = ST_ACCEPT;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_ACCEPT: req_ready = !rsp_valid_ff || rsp_bus.ready;
         ST_REPORT: load_rsp  = 1'b1;
         default: begin
            req_ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   // request decode: cell control, fill count and drop flag
   always_comb begin
      ctrl.ins   = 1'b0;
      ctrl.rmax  = 1'b0;
      ctrl.value = req_bus.value;
      count_in   = count_ff;
      drop_in    = drop_ff;
      if (accept) begin
         drop_in = 1'b0;
         unique case (op)
            OP_INSERT: begin
               if (full) begin
                  drop_in = 1'b1;
               end else begin
                  ctrl.ins = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            OP_REMOVE_MIN: begin
               if (!empty) count_in = count_ff - CNT_W'(1);
            end
            OP_REMOVE_MAX: begin
               if (!empty) begin
                  ctrl.rmax = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            default: drop_in = 1'b0;
         endcase
      end
   end

   // row of cells, each wired to its two neighbors
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic                     occ;
      logic                     l_take;
      logic signed [DATA_W-1:0] l_val;
      logic signed [DATA_W-1:0] r_val;

      assign occ = (CNT_W'(g) < count_ff);

      if (g == 0) begin : g_first
         assign l_take = 1'b0;
         assign l_val  = req_bus.value;
      end else begin : g_mid
         assign l_take = cell_take[g-1];
         assign l_val  = cell_val[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
         assign r_val = cell_val[g];
      end else begin : g_inner
         assign r_val = cell_val[g+1];
      end

      sdepq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ),
         .left_take   (l_take),
         .left_value  (l_val),
         .right_value (r_val),
         .value       (cell_val[g]),
         .take        (cell_take[g])
      );
   end

   // response word selection
   assign last_pos   = count_ff - CNT_W'(1);
   assign count_wide = (CNT_W + COUNT_OUT_W)'(count_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCEPT;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_min_ff   <= empty ? EMPTY_VALUE : cell_val[last_pos[IDX_W-1:0]];
         rsp_max_ff   <= empty ? EMPTY_VALUE : cell_val[0];
         rsp_count_ff <= count_wide[COUNT_OUT_W-1:0];
         rsp_empty_ff <= empty;
         rsp_drop_ff  <= drop_ff;
      end
   end

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.min_value      = rsp_min_ff;
   assign rsp_bus.max_value      = rsp_max_ff;
   assign rsp_bus.count          = rsp_count_ff;
   assign rsp_bus.is_empty       = rsp_empty_ff;
   assign rsp_bus.insert_dropped = rsp_drop_ff;
endmodule

@@ rtl/sdepq_checker.sv @@
// port-level checker for the priority queue and its bind
`include "assert_macros.svh"

module sdepq_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic signed [sdepq_pkg::DATA_W-1:0] rsp_min_value,
   input logic signed [sdepq_pkg::DATA_W-1:0] rsp_max_value,
   input logic [sdepq_pkg::COUNT_OUT_W-1:0]   rsp_count,
   input logic                                rsp_is_empty
);
   import sdepq_pkg::*;

   // empty flag agrees with the count
   `ASSERT_IMPLY(a_empty_count, clock, reset, rsp_valid, rsp_is_empty == (rsp_count == '0))

   // an empty queue reads all ones on both ends
   `ASSERT_IMPLY(a_empty_reads, clock, reset, rsp_valid && rsp_is_empty,
                 (rsp_min_value == EMPTY_VALUE) && (rsp_max_value == EMPTY_VALUE))

   // sorted row: minimum never above maximum
   `ASSERT_IMPLY(a_min_le_max, clock, reset, rsp_valid && !rsp_is_empty,
                 rsp_min_value <= rsp_max_value)

   // one word in flight: no accept right after an accept
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind sorted_double_ended_priority_queue_top sdepq_checker u_sdepq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_min_value (rsp_bus.min_value),
   .rsp_max_value (rsp_bus.max_value),
   .rsp_count     (rsp_bus.count),
   .rsp_is_empty  (rsp_bus.is_empty)
);
